### src/box_downsample_2x2_unit_assert.svh
// Assertion macros for the 2x2 box downsampler.
`ifndef BOX_DOWNSAMPLE_2X2_UNIT_ASSERT_SVH
`define BOX_DOWNSAMPLE_2X2_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bds assertion failed");

// Check that cons holds in the cycle after ante.
`define BDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bds assertion failed");

`endif

### src/bds_pkg.sv
package bds_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int LANES       = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int PAIR_BITS   = SAMPLE_BITS + 1;
    localparam int LINE_DEPTH  = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS    = 13;
    localparam int CH_BITS     = 3;
    localparam int IDX_BITS    = 2;

    localparam logic [IDX_BITS-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_CH_COUNT   = 2'd2;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ADDR_BITS-1:0]   t_addr;

    typedef struct packed {
        logic  accept;
        logic  clear;
        logic  hold;
        logic  wr;
        logic  dbl_pair;
        logic  dbl_total;
        logic  active;
        t_addr addr;
    } t_lane_ctl;

endpackage

### src/box_downsample_2x2_unit.sv
// 2x2 box downsampler, one pyramid level.
// Input channel: one source pixel per beat in raster order (i_valid, o_stall),
// four 16-bit channel samples. Output channel: one pixel per 2x2 block
// (o_valid, i_stall) with the rounded mean per channel, o_row_end on the last
// pixel of an output row and o_image_end on the last pixel of the image.
// Configuration: i_cfg_valid / o_cfg_ready write one register per beat
// (width, height, channel count); a write to any of the three restarts the frame.
// Throughput: one source pixel per cycle while o_stall is low; each of the
// four lanes reads its own line store once per pixel and writes it when an
// upper-row pair closes. Results pass the lane stage, then the output register.
// Beats of even rows and columns, bar the last, only update line store and holds.
// When the receiver stalls, the output register holds its beat and one more
// result waits in the lane stage; o_stall rises when both are full, and
// during a configuration write.
// Reset (synchronous, active low) restarts the frame and sets the registers
// to 4096 x 4096 with four channels; no line store clearing is needed.
module box_downsample_2x2_unit
    import bds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_BITS-1:0] i_cfg_index,
    input  logic [DIM_BITS-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_sample             i_sample_c0,
    input  t_sample             i_sample_c1,
    input  t_sample             i_sample_c2,
    input  t_sample             i_sample_c3,
    output logic                o_valid,
    input  logic                i_stall,
    output t_sample             o_mean_c0,
    output t_sample             o_mean_c1,
    output t_sample             o_mean_c2,
    output t_sample             o_mean_c3,
    output logic                o_row_end,
    output logic                o_image_end
);

`include "box_downsample_2x2_unit_assert.svh"

    logic [DIM_BITS-1:0] r_src_width;
    logic [DIM_BITS-1:0] r_src_height;
    logic [CH_BITS-1:0]  r_ch_count;
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;
    logic                r_s1_vld;
    logic                r_s1_row_end;
    logic                r_s1_img_end;

    logic                w_cfg_wr;
    logic                w_restart;
    logic [COL_BITS-1:0] w_wm1;
    logic [ROW_BITS-1:0] w_hm1;
    logic [CH_BITS-1:0]  w_ch;
    logic [COL_BITS-1:0] w_col_c;
    logic                w_last_col;
    logic                w_last_row;
    logic                w_even_col;
    logic                w_even_row;
    logic                w_hold;
    logic                w_wr;
    logic                w_emit;
    logic                w_accept;
    logic                w_s1_free;
    logic                w_out_free;
    logic                w_load_out;
    t_sample             w_sample [LANES];
    t_sample             w_lane_mean [LANES];
    t_sample             w_out_mean [LANES];
    t_lane_ctl           w_ctl [LANES];

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    always_comb begin
        case (i_cfg_index)
            CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_CH_COUNT: w_restart = w_cfg_wr;
            default:                                     w_restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_BITS'(MAX_WIDTH);
            r_src_height <= DIM_BITS'(MAX_HEIGHT);
            r_ch_count   <= CH_BITS'(LANES);
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                CFG_CH_COUNT:   r_ch_count   <= i_cfg_data[CH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_src_width == '0) begin
            w_wm1 = '0;
        end else if (r_src_width > DIM_BITS'(MAX_WIDTH)) begin
            w_wm1 = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_wm1 = COL_BITS'(r_src_width - DIM_BITS'(1));
        end
        if (r_src_height == '0) begin
            w_hm1 = '0;
        end else if (r_src_height > DIM_BITS'(MAX_HEIGHT)) begin
            w_hm1 = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            w_hm1 = ROW_BITS'(r_src_height - DIM_BITS'(1));
        end
        if (r_ch_count == '0) begin
            w_ch = CH_BITS'(1);
        end else if (r_ch_count > CH_BITS'(LANES)) begin
            w_ch = CH_BITS'(LANES);
        end else begin
            w_ch = r_ch_count;
        end
    end

    assign w_last_col = r_col >= w_wm1;
    assign w_last_row = r_row >= w_hm1;
    assign w_even_col = !r_col[0];
    assign w_even_row = !r_row[0];
    assign w_col_c    = (r_col > w_wm1) ? w_wm1 : r_col;
    assign w_hold     = w_even_col && !w_last_col;
    assign w_wr       = !w_hold && w_even_row && !w_last_row;
    assign w_emit     = !w_hold && !(w_even_row && !w_last_row);

    assign w_s1_free  = !r_s1_vld || w_out_free;
    assign o_stall    = !w_s1_free || w_cfg_wr;
    assign w_accept   = i_valid && w_s1_free && !w_cfg_wr;
    assign w_load_out = r_s1_vld && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + ROW_BITS'(1);
            end else begin
                r_col <= w_col_c + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= w_emit;
        end else if (w_out_free) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row_end <= w_last_col;
            r_s1_img_end <= w_last_col && w_last_row;
        end
    end

    assign w_sample[0] = i_sample_c0;
    assign w_sample[1] = i_sample_c1;
    assign w_sample[2] = i_sample_c2;
    assign w_sample[3] = i_sample_c3;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        assign w_ctl[g].accept    = w_accept;
        assign w_ctl[g].clear     = w_restart;
        assign w_ctl[g].hold      = w_hold;
        assign w_ctl[g].wr        = w_wr;
        assign w_ctl[g].dbl_pair  = w_even_col;
        assign w_ctl[g].dbl_total = w_even_row;
        assign w_ctl[g].active    = CH_BITS'(g) < w_ch;
        assign w_ctl[g].addr      = ADDR_BITS'(w_col_c >> 1);

        bds_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[g]),
            .i_sample (w_sample[g]),
            .o_mean   (w_lane_mean[g])
        );
    end

    bds_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load_out),
        .i_means     (w_lane_mean),
        .i_row_end   (r_s1_row_end),
        .i_image_end (r_s1_img_end),
        .i_stall     (i_stall),
        .o_free      (w_out_free),
        .o_valid     (o_valid),
        .o_means     (w_out_mean),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end)
    );

    assign o_mean_c0 = w_out_mean[0];
    assign o_mean_c1 = w_out_mean[1];
    assign o_mean_c2 = w_out_mean[2];
    assign o_mean_c3 = w_out_mean[3];

    `BDS_ASSERT_NOW(a_img_end_row_end, i_clk, i_rst_n, o_valid && o_image_end, o_row_end)
    `BDS_ASSERT_NOW(a_col_in_range, i_clk, i_rst_n, !w_restart, r_col <= w_wm1 || w_wm1 == '0)
    `BDS_ASSERT_NEXT(a_restart_zero, i_clk, i_rst_n, w_restart, r_col == '0 && r_row == '0)
    `BDS_ASSERT_NEXT(a_row_advance, i_clk, i_rst_n,
        w_accept && w_last_col && !w_last_row && !w_restart,
        r_col == '0 && r_row == $past(r_row) + ROW_BITS'(1))

endmodule

### src/bds_lane.sv
module bds_lane
    import bds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_sample,
    output t_sample   o_mean
);

    logic [PAIR_BITS-1:0] mem [LINE_DEPTH];

    t_sample              r_left;
    logic [PAIR_BITS-1:0] r_rd;
    logic [PAIR_BITS-1:0] r_pair;
    logic                 r_dbl;
    logic                 r_act;

    t_sample              w_s;
    logic [PAIR_BITS-1:0] w_pair;
    logic [PAIR_BITS:0]   w_total;
    logic [PAIR_BITS:0]   w_round;

    assign w_s    = i_ctl.active ? i_sample : '0;
    assign w_pair = i_ctl.dbl_pair ? {w_s, 1'b0} : ({1'b0, r_left} + {1'b0, w_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_left <= '0;
        end else if (i_ctl.accept && i_ctl.hold) begin
            r_left <= w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_ctl.wr) begin
            mem[i_ctl.addr] <= w_pair;
        end
        if (i_ctl.accept) begin
            r_rd <= mem[i_ctl.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_pair <= w_pair;
            r_dbl  <= i_ctl.dbl_total;
            r_act  <= i_ctl.active;
        end
    end

    assign w_total = r_dbl ? {r_pair, 1'b0} : ({1'b0, r_rd} + {1'b0, r_pair});
    assign w_round = w_total + (PAIR_BITS+1)'(2);
    assign o_mean  = r_act ? w_round[PAIR_BITS:2] : '0;

endmodule

### src/bds_merge.sv
module bds_merge
    import bds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_sample i_means [LANES],
    input  logic    i_row_end,
    input  logic    i_image_end,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_sample o_means [LANES],
    output logic    o_row_end,
    output logic    o_image_end
);

    logic    r_vld;
    t_sample r_means [LANES];
    logic    r_row_end;
    logic    r_image_end;

    assign o_free = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_means     <= i_means;
            r_row_end   <= i_row_end;
            r_image_end <= i_image_end;
        end
    end

    assign o_valid     = r_vld;
    assign o_means     = r_means;
    assign o_row_end   = r_row_end;
    assign o_image_end = r_image_end && r_row_end;

endmodule
